// File: hw/rtl/erdd_pkg.sv
package erdd_pkg;

  // Field widths
  localparam int OVF_W     = 5;
  localparam int TICKS_W   = 8;
  localparam int ELAPSED_W = 13;
  localparam int DIST_W    = 12;
  localparam int THR_W     = 8;
  localparam int EVT_W     = 2;

  // Echo-to-distance conversion: elapsed*683 >> 10 tenths of a cm
  localparam int PROD_W            = 23;
  localparam int SCALE_SHIFT       = 10;
  localparam int TICKS_PER_OVF     = 255;
  localparam int SCALE_NUM         = 683;
  localparam int DIST_MAX          = 4095;
  localparam int TENTHS_PER_CM     = 10;

  // Register reset values
  localparam logic [THR_W-1:0]     NEAR_THRESHOLD_RST = 8'd90;
  localparam logic [ELAPSED_W-1:0] MAX_ECHO_RST       = 13'd4439;
  localparam logic [ELAPSED_W-1:0] MIN_ECHO_RST       = 13'd28;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_NEAR_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MAX_ECHO       = 2'd1;
  localparam logic [1:0] REG_MIN_ECHO       = 2'd2;

  // Depth of the queue between classifier and tracker
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE    = 2'd0,
    EVT_A_FIRST = 2'd1,
    EVT_B_FIRST = 2'd2
  } dir_evt_t;

  // One classified reading pair
  typedef struct packed {
    logic [DIST_W-1:0] distance_a;
    logic [DIST_W-1:0] distance_b;
    logic              near_a;
    logic              near_b;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: hw/rtl/erdd_front.sv
module erdd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [erdd_pkg::OVF_W-1:0]         overflows_a,
  input  logic [erdd_pkg::TICKS_W-1:0]       ticks_a,
  input  logic [erdd_pkg::OVF_W-1:0]         overflows_b,
  input  logic [erdd_pkg::TICKS_W-1:0]       ticks_b,
  input  logic [erdd_pkg::THR_W-1:0]         near_threshold_cm,
  input  logic [erdd_pkg::ELAPSED_W-1:0]     max_echo_ticks,
  input  logic [erdd_pkg::ELAPSED_W-1:0]     min_echo_ticks,
  output logic                               item_valid,
  input  logic                               item_ready,
  output erdd_pkg::item_t                    item
);

  localparam int EW = erdd_pkg::ELAPSED_W;
  localparam int PW = erdd_pkg::PROD_W;
  localparam int DW = erdd_pkg::DIST_W;

  logic [EW-1:0] elapsed_a, elapsed_b;
  logic [PW-1:0] prod_a, prod_b;
  logic [EW-1:0] scaled_a, scaled_b;
  logic [DW-1:0] dist_a, dist_b;
  logic [DW-1:0] near_limit;
  logic          band_a, band_b;
  erdd_pkg::item_t item_next;

  assign elapsed_a = EW'(overflows_a) * EW'(erdd_pkg::TICKS_PER_OVF) + EW'(ticks_a);
  assign elapsed_b = EW'(overflows_b) * EW'(erdd_pkg::TICKS_PER_OVF) + EW'(ticks_b);

  assign band_a = (elapsed_a < max_echo_ticks) && (elapsed_a > min_echo_ticks);
  assign band_b = (elapsed_b < max_echo_ticks) && (elapsed_b > min_echo_ticks);

  assign prod_a   = PW'(elapsed_a) * PW'(erdd_pkg::SCALE_NUM);
  assign prod_b   = PW'(elapsed_b) * PW'(erdd_pkg::SCALE_NUM);
  assign scaled_a = prod_a[erdd_pkg::SCALE_SHIFT +: EW];
  assign scaled_b = prod_b[erdd_pkg::SCALE_SHIFT +: EW];

  always_comb begin
    dist_a = '0;
    dist_b = '0;
    if (band_a) begin
      dist_a = (scaled_a > EW'(erdd_pkg::DIST_MAX)) ? DW'(erdd_pkg::DIST_MAX) : scaled_a[DW-1:0];
    end
    if (band_b) begin
      dist_b = (scaled_b > EW'(erdd_pkg::DIST_MAX)) ? DW'(erdd_pkg::DIST_MAX) : scaled_b[DW-1:0];
    end
  end

  assign near_limit = DW'(near_threshold_cm) * DW'(erdd_pkg::TENTHS_PER_CM);

  always_comb begin
    item_next.distance_a = dist_a;
    item_next.distance_b = dist_b;
    item_next.near_a     = (dist_a <= near_limit);
    item_next.near_b     = (dist_b <= near_limit);
  end

  // Take a new reading whenever the stage is empty or drains this cycle
  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// File: hw/rtl/erdd_queue.sv
module erdd_queue #(
  parameter int DEPTH = erdd_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  erdd_pkg::item_t         push_data,
  input  logic                    pop,
  output erdd_pkg::item_t         head,
  output erdd_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  erdd_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/erdd_back.sv
module erdd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  erdd_pkg::item_t              item,
  output logic                         item_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [erdd_pkg::DIST_W-1:0]  distance_a,
  output logic [erdd_pkg::DIST_W-1:0]  distance_b,
  output erdd_pkg::dir_evt_t           direction_event
);

  typedef enum logic [2:0] {
    IDLE     = 3'd0,
    A_HELD   = 3'd1,
    A_WAIT_B = 3'd2,
    B_HELD   = 3'd3,
    B_WAIT_A = 3'd4
  } phase_t;

  phase_t phase;

  // Advance on a queued item whenever the output slot is free or being taken
  assign item_pop = item_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (item_pop) begin
        out_valid       <= 1'b1;
        distance_a      <= item.distance_a;
        distance_b      <= item.distance_b;
        direction_event <= erdd_pkg::EVT_NONE;
        case (phase)
          A_HELD: begin
            if (!item.near_a) phase <= A_WAIT_B;
          end
          A_WAIT_B: begin
            if (!item.near_b) begin
              direction_event <= erdd_pkg::EVT_A_FIRST;
              phase           <= IDLE;
            end
          end
          B_HELD: begin
            if (!item.near_b) phase <= B_WAIT_A;
          end
          B_WAIT_A: begin
            if (!item.near_a) begin
              direction_event <= erdd_pkg::EVT_B_FIRST;
              phase           <= IDLE;
            end
          end
          default: begin
            if (item.near_a) begin
              phase <= A_HELD;
            end else if (item.near_b) begin
              phase <= B_HELD;
            end else begin
              phase <= IDLE;
            end
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/echo_range_direction_detector_top.sv
// Two-sensor echo range and direction detector.
//
// Input stream (s_*): one transaction carries an echo-time reading for
// sensor A and one for sensor B. Output stream (m_*): exactly one
// transaction per input, with both filtered distances in tenths of a cm
// and a direction code (none, A tripped first, B tripped first).
// The APB port holds the near threshold and the echo band limits; write
// it only while no readings are in flight.
//
// Path: an accepted reading loads the classifier register, then a queue
// slot, then the output register, which raises m_tvalid. Throughput: one
// transaction per cycle while m_tready is high, set by the combinational
// scale multiply in the classifier and the one-step phase tracker.
//
// Reset (rst, synchronous) empties the pipeline, returns the tracker to
// idle and loads the register defaults. When the receiver stalls, the
// output holds, the queue fills, and s_tready drops only once the queue
// and the classifier register are both full.
module echo_range_direction_detector_top #(
  parameter int QUEUE_DEPTH = erdd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // overflows_a[4:0], ticks_a[12:5],
                                 // overflows_b[17:13], ticks_b[25:18], zero pad
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // distance_a[11:0], distance_b[23:12],
                                 // direction_event[25:24], zero pad
);

  localparam int OW = erdd_pkg::OVF_W;
  localparam int TW = erdd_pkg::TICKS_W;
  localparam int EW = erdd_pkg::ELAPSED_W;
  localparam int DW = erdd_pkg::DIST_W;

  // Configuration registers
  logic [erdd_pkg::THR_W-1:0] near_threshold_cm;
  logic [EW-1:0]              max_echo_ticks;
  logic [EW-1:0]              min_echo_ticks;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold_cm <= erdd_pkg::NEAR_THRESHOLD_RST;
      max_echo_ticks    <= erdd_pkg::MAX_ECHO_RST;
      min_echo_ticks    <= erdd_pkg::MIN_ECHO_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        erdd_pkg::REG_NEAR_THRESHOLD: near_threshold_cm <= pwdata[erdd_pkg::THR_W-1:0];
        erdd_pkg::REG_MAX_ECHO:       max_echo_ticks    <= pwdata[EW-1:0];
        erdd_pkg::REG_MIN_ECHO:       min_echo_ticks    <= pwdata[EW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      erdd_pkg::REG_NEAR_THRESHOLD: prdata = 32'(near_threshold_cm);
      erdd_pkg::REG_MAX_ECHO:       prdata = 32'(max_echo_ticks);
      erdd_pkg::REG_MIN_ECHO:       prdata = 32'(min_echo_ticks);
      default:                      prdata = '0;
    endcase
  end

  // Front: classify readings into distances and near flags
  logic                    front_valid;
  erdd_pkg::item_t         front_item;
  erdd_pkg::queue_status_t q_status;
  erdd_pkg::item_t         q_head;
  logic                    q_push, q_pop;

  erdd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .overflows_a       (s_tdata[OW-1:0]),
    .ticks_a           (s_tdata[OW +: TW]),
    .overflows_b       (s_tdata[OW+TW +: OW]),
    .ticks_b           (s_tdata[2*OW+TW +: TW]),
    .near_threshold_cm (near_threshold_cm),
    .max_echo_ticks    (max_echo_ticks),
    .min_echo_ticks    (min_echo_ticks),
    .item_valid        (front_valid),
    .item_ready        (!q_status.full),
    .item              (front_item)
  );

  assign q_push = front_valid && !q_status.full;

  // Queue decouples the classifier from the output side
  erdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // Back: track which sensor trips first and drive the output register
  logic [DW-1:0]      out_distance_a, out_distance_b;
  erdd_pkg::dir_evt_t out_event;

  erdd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (!q_status.empty),
    .item            (q_head),
    .item_pop        (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .distance_a      (out_distance_a),
    .distance_b      (out_distance_b),
    .direction_event (out_event)
  );

  assign m_tdata = {6'b0, out_event, out_distance_b, out_distance_a};

  // After reset nothing is pending and the input side is open
  a_reset_clean: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("output valid or input stalled right after reset");

  // Only the three defined direction codes ever leave the block
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[25:24] != 2'b11))
    else $error("undefined direction code on output");

  // A push without a pop leaves the queue non-empty
  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !q_status.empty)
    else $error("queue lost an item");

  // Never pop an empty queue
  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule
